@@ sv/gske_pkg.sv @@
// Shared types, constants and pseudo-float helpers for the Gaussian SPH kernel evaluator.
`timescale 1ns / 1ps
`default_nettype none
package gske_pkg;

    typedef logic signed [12:0] exp_t;

    typedef struct packed {
        logic [31:0] m;
        exp_t        e;
    } pf_t;

    typedef struct packed {
        logic        sat;
        logic [47:0] mag;
    } omag_t;

    localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
    localparam logic [31:0] LN2_Q32  = 32'd2977044472;
    localparam pf_t         LOG2E_PF = '{m: 32'd3098164009, e: -13'sd31};
    localparam logic [31:0] A2D_M    = 32'd2734261102;
    localparam logic [31:0] A3D_M    = 32'd3085283264;
    localparam logic [31:0] MSB_M    = 32'h8000_0000;
    localparam logic [47:0] POS_CAP  = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_CAP  = 48'h8000_0000_0000;
    localparam exp_t        EXP_IH   = -13'sd63;
    localparam exp_t        EXP_IHP  = -13'sd62;
    localparam exp_t        EXP_Q32  = -13'sd32;
    localparam exp_t        EXP_SAT  = 13'sd17;
    localparam int          HORNER_TERMS = 13;

    localparam logic [31:0] RECIP_TBL [0:15] = '{
        32'd0, 32'd0, 32'd2147483648, 32'd1431655765,
        32'd1073741824, 32'd858993459, 32'd715827882, 32'd613566756,
        32'd536870912, 32'd477218588, 32'd429496729, 32'd390451572,
        32'd357913941, 32'd330382099, 32'd0, 32'd0
    };

    function automatic pf_t pf_norm(input logic [63:0] v, input exp_t e0);
        pf_t         r;
        int          pos;
        logic [63:0] sh;
        r   = '0;
        pos = 0;
        sh  = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                pos = i;
            end
        end
        if (v != '0)
        begin
            if (pos >= 31)
            begin
                sh = v >> (pos - 31);
            end
            else
            begin
                sh = v << (31 - pos);
            end
            r.m = sh[31:0];
            r.e = e0 + exp_t'(pos) - exp_t'(31);
        end
        return r;
    endfunction

    function automatic pf_t pf_mul(input pf_t a, input pf_t b);
        pf_t         r;
        logic [63:0] p;
        r = '0;
        p = {32'd0, a.m} * {32'd0, b.m};
        if (a.m != '0 && b.m != '0)
        begin
            if (p[63])
            begin
                r.m = p[63:32];
                r.e = a.e + b.e + exp_t'(32);
            end
            else
            begin
                r.m = p[62:31];
                r.e = a.e + b.e + exp_t'(31);
            end
        end
        return r;
    endfunction

    function automatic logic [63:0] pf_fix32(input pf_t a);
        logic [63:0] v;
        exp_t        s;
        exp_t        ns;
        v  = '0;
        s  = a.e + exp_t'(32);
        ns = -s;
        if (a.m != '0)
        begin
            if (s >= 0)
            begin
                if (s > exp_t'(31))
                begin
                    v = '1;
                end
                else
                begin
                    v = {32'd0, a.m} << s[4:0];
                end
            end
            else if (ns < exp_t'(64))
            begin
                v = {32'd0, a.m} >> ns[5:0];
            end
        end
        return v;
    endfunction

    function automatic omag_t pf_out_mag(input pf_t a, input logic neg);
        omag_t       r;
        logic [47:0] cap;
        logic [63:0] v;
        exp_t        ne;
        r   = '0;
        cap = neg ? NEG_CAP : POS_CAP;
        v   = '0;
        ne  = -a.e;
        if (a.m != '0)
        begin
            if (a.e >= EXP_SAT)
            begin
                r.sat = 1'b1;
                r.mag = cap;
            end
            else
            begin
                if (a.e >= 0)
                begin
                    v = {32'd0, a.m} << a.e[4:0];
                end
                else if (ne < exp_t'(64))
                begin
                    v = {32'd0, a.m} >> ne[5:0];
                end
                if (v > {16'd0, cap})
                begin
                    r.sat = 1'b1;
                    r.mag = cap;
                end
                else
                begin
                    r.mag = v[47:0];
                end
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ sv/gaussian_sph_kernel_eval.sv @@
// Pipelined Gaussian SPH kernel evaluator: W, dW and d2W from distance and smoothing length.
//
// Channel | Signals                          | Transaction contents
// s_axis  | tvalid tready tdata[63:0]        | distance, smoothing_length
// m_axis  | tvalid tready tdata[143:0] tuser | kernel_value, first/second_derivative; flags
// cfg     | valid ready data                 | dimension_mode
//
// One transaction per cycle sustained while the skid entry is empty; a full skid entry holds the input.
// Most of the pipeline is the 37-step restoring quotient divider and the 13-term exp series,
// three stages a term (multiply, reciprocal multiply, correction).
// Reset clears all valid bits and selects 2D normalization.
// The whole pipeline holds only while both the output register and the skid entry are full.
`timescale 1ns / 1ps
`default_nettype none
module gaussian_sph_kernel_eval
    import gske_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // [31:0] distance, [62:32] smoothing_length
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [143:0]      m_axis_tdata,   // [47:0] kernel_value, [95:48] first_derivative,
                                              // [143:96] second_derivative
    output logic [1:0]        m_axis_tuser,   // [0] saturated, [1] bad_length
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic         cfg_data
);

    localparam int   NQ     = 37;
    localparam int   NI     = 32;
    localparam int   S_N1   = NQ + 1;
    localparam int   S_N2   = S_N1 + 1;
    localparam int   S_N3   = S_N2 + 1;
    localparam int   S_N4   = S_N3 + 1;
    localparam int   S_N5   = S_N4 + 1;
    localparam int   S_H0   = S_N5 + 1;
    localparam int   S_E1   = S_H0 + 3 * HORNER_TERMS;
    localparam int   S_E2   = S_E1 + 1;
    localparam int   S_E3   = S_E2 + 1;
    localparam int   S_E4   = S_E3 + 1;
    localparam int   S_E5   = S_E4 + 1;
    localparam int   S_O1   = S_E5 + 1;
    localparam int   S_O2   = S_O1 + 1;
    localparam int   NST    = S_O2 + 1;
    localparam exp_t FRAC_E = exp_t'(FRAC_BITS);
    localparam exp_t A2D_E  = exp_t'(-33 + 3 * FRAC_BITS);
    localparam exp_t A3D_E  = exp_t'(-34 + 4 * FRAC_BITS);

    typedef struct packed {
        logic        dneg;
        logic        bad;
        logic        far;
        logic        hpow;
        logic        d2neg;
        logic        sat;
        logic [31:0] dmag;
        logic [30:0] h;
        logic [30:0] rem_q;
        logic [36:0] quo_q;
        logic [30:0] hn;
        exp_t        he;
        logic [30:0] rem_i;
        logic [31:0] quo_i;
        pf_t         r;
        pf_t         ih;
        pf_t         a;
        pf_t         r2;
        pf_t         x;
        logic [42:0] r2fix;
        logic [43:0] dmg;
        pf_t         dmgn;
        logic [10:0] n;
        logic [31:0] f;
        logic [31:0] y;
        logic [32:0] p;
        logic [31:0] v;
        logic [31:0] qe;
        pf_t         e;
        pf_t         w;
        pf_t         g;
        pf_t         dw;
        pf_t         h2;
        pf_t         d2;
        logic [47:0] mw;
        logic [47:0] mdw;
        logic [47:0] md2;
        logic [47:0] kv;
        logic [47:0] fd;
        logic [47:0] sd;
    } item_t;

    item_t            pipe_reg  [0:NST-1];
    item_t            pipe_next [0:NST-1];
    logic [NST-1:0]   vld_reg;
    logic             dim_reg;
    logic             en;
    logic             push;
    logic             pop;
    logic [145:0]     res_next;
    logic [145:0]     out_reg;
    logic [145:0]     skid_reg;
    logic             out_vld_reg;
    logic             skid_vld_reg;

    assign en            = !skid_vld_reg;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;
    assign push          = en && vld_reg[NST-1];
    assign pop           = out_vld_reg && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            dim_reg <= cfg_data;
        end
    end

    always_comb
    begin
        item_t nx;
        logic [31:0] d;
        nx          = '0;
        d           = s_axis_tdata[31:0];
        nx.h        = s_axis_tdata[62:32];
        nx.dneg     = d[31];
        nx.dmag     = d[31] ? (~d + 32'd1) : d;
        nx.bad      = (nx.h == '0);
        nx.far      = ({4'd0, nx.dmag} >= {nx.h, 5'd0});
        nx.rem_q    = {4'd0, nx.dmag[31:5]};
        pipe_next[0] = nx;
    end

    for (genvar j = 0; j < NQ; j++)
    begin : g_div
        always_comb
        begin
            item_t       it;
            item_t       nx;
            logic [31:0] tq;
            logic [31:0] dq;
            logic [31:0] ti;
            logic [31:0] di;
            logic        qb;
            logic        ib;
            pf_t         nh;
            it = pipe_reg[j];
            nx = it;
            tq = {it.rem_q, it.dmag[4]};
            dq = tq - {1'b0, it.h};
            qb = (tq >= {1'b0, it.h});
            nx.rem_q = qb ? dq[30:0] : tq[30:0];
            nx.quo_q = {it.quo_q[35:0], qb};
            nx.dmag  = {it.dmag[30:0], 1'b0};
            nh = pf_norm({33'd0, it.h}, exp_t'(0));
            ti = {it.rem_i, 1'b0};
            di = ti - {1'b0, it.hn};
            ib = (ti >= {1'b0, it.hn});
            if (j == 0)
            begin
                nx.hn    = nh.m[31:1];
                nx.he    = nh.e;
                nx.hpow  = (nh.m == MSB_M);
                nx.rem_i = 31'h4000_0000;
                nx.quo_i = '0;
            end
            else if (j <= NI)
            begin
                nx.rem_i = ib ? di[30:0] : ti[30:0];
                nx.quo_i = {it.quo_i[30:0], ib};
            end
            pipe_next[j+1] = nx;
        end
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it    = pipe_reg[S_N1-1];
        nx    = it;
        nx.r  = pf_norm({27'd0, it.quo_q}, EXP_Q32);
        if (it.hpow)
        begin
            nx.ih.m = MSB_M;
            nx.ih.e = EXP_IHP - it.he;
        end
        else
        begin
            nx.ih.m = it.quo_i;
            nx.ih.e = EXP_IH - it.he;
        end
        nx.a.m = dim_reg ? A3D_M : A2D_M;
        nx.a.e = dim_reg ? A3D_E : A2D_E;
        pipe_next[S_N1] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it    = pipe_reg[S_N2-1];
        nx    = it;
        nx.r2 = pf_mul(it.r, it.r);
        nx.a  = pf_mul(it.a, it.ih);
        pipe_next[S_N2] = nx;
    end

    always_comb
    begin
        item_t       it;
        item_t       nx;
        logic [63:0] fx;
        it       = pipe_reg[S_N3-1];
        nx       = it;
        fx       = pf_fix32(it.r2);
        nx.x     = pf_mul(it.r2, LOG2E_PF);
        nx.a     = pf_mul(it.a, it.ih);
        nx.r2fix = fx[42:0];
        pipe_next[S_N3] = nx;
    end

    always_comb
    begin
        item_t       it;
        item_t       nx;
        logic [63:0] t;
        logic [43:0] u;
        it = pipe_reg[S_N4-1];
        nx = it;
        t  = pf_fix32(it.x);
        nx.n = t[42:32];
        nx.f = t[31:0];
        if (dim_reg)
        begin
            nx.a = pf_mul(it.a, it.ih);
        end
        u = {it.r2fix, 1'b0};
        if (u <= {11'd0, ONE_Q32})
        begin
            nx.dmg   = {11'd0, ONE_Q32} - u;
            nx.d2neg = 1'b1;
        end
        else
        begin
            nx.dmg   = u - {11'd0, ONE_Q32};
            nx.d2neg = 1'b0;
        end
        pipe_next[S_N4] = nx;
    end

    always_comb
    begin
        item_t       it;
        item_t       nx;
        logic [63:0] yp;
        it      = pipe_reg[S_N5-1];
        nx      = it;
        yp      = {32'd0, it.f} * {32'd0, LN2_Q32};
        nx.y    = yp[63:32];
        nx.p    = ONE_Q32;
        nx.dmgn = pf_norm({20'd0, it.dmg}, EXP_Q32);
        pipe_next[S_N5] = nx;
    end

    for (genvar s = 0; s < HORNER_TERMS; s++)
    begin : g_horner
        localparam int          K  = HORNER_TERMS - s;
        localparam logic [3:0]  KC = 4'(K);
        localparam logic [31:0] MK = RECIP_TBL[K];

        always_comb
        begin
            item_t       it;
            item_t       nx;
            logic [64:0] pr;
            it   = pipe_reg[S_H0+3*s-1];
            nx   = it;
            pr   = {33'd0, it.y} * {32'd0, it.p};
            nx.v = pr[63:32];
            pipe_next[S_H0+3*s] = nx;
        end

        always_comb
        begin
            item_t       it;
            item_t       nx;
            logic [63:0] pr;
            it = pipe_reg[S_H0+3*s];
            nx = it;
            pr = {32'd0, it.v} * {32'd0, MK};
            if (K == 1)
            begin
                nx.qe = it.v;
            end
            else
            begin
                nx.qe = pr[63:32];
            end
            pipe_next[S_H0+3*s+1] = nx;
        end

        always_comb
        begin
            item_t       it;
            item_t       nx;
            logic [35:0] pk;
            logic [35:0] rm;
            logic [31:0] qv;
            it = pipe_reg[S_H0+3*s+1];
            nx = it;
            pk = {4'd0, it.qe} * {32'd0, KC};
            rm = {4'd0, it.v} - pk;
            if (K == 1)
            begin
                qv = it.v;
            end
            else if (rm >= {32'd0, KC})
            begin
                qv = it.qe + 32'd1;
            end
            else
            begin
                qv = it.qe;
            end
            nx.p = ONE_Q32 - {1'b0, qv};
            pipe_next[S_H0+3*s+2] = nx;
        end
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it   = pipe_reg[S_E1-1];
        nx   = it;
        nx.e = pf_norm({31'd0, it.p}, EXP_Q32 - exp_t'({2'd0, it.n}));
        pipe_next[S_E1] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it   = pipe_reg[S_E2-1];
        nx   = it;
        nx.w = pf_mul(it.a, it.e);
        pipe_next[S_E2] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it     = pipe_reg[S_E3-1];
        nx     = it;
        nx.g   = pf_mul(it.w, it.ih);
        nx.g.e = nx.g.e + FRAC_E;
        pipe_next[S_E3] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it      = pipe_reg[S_E4-1];
        nx      = it;
        nx.dw   = pf_mul(it.r, it.g);
        nx.dw.e = nx.dw.e + exp_t'(1);
        nx.h2   = pf_mul(it.g, it.ih);
        nx.h2.e = nx.h2.e + FRAC_E;
        pipe_next[S_E4] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it      = pipe_reg[S_E5-1];
        nx      = it;
        nx.d2   = pf_mul(it.dmgn, it.h2);
        nx.d2.e = nx.d2.e + exp_t'(1);
        pipe_next[S_E5] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        omag_t o0;
        omag_t o1;
        omag_t o2;
        it     = pipe_reg[S_O1-1];
        nx     = it;
        o0     = pf_out_mag(it.w, 1'b0);
        o1     = pf_out_mag(it.dw, !it.dneg);
        o2     = pf_out_mag(it.d2, it.d2neg);
        nx.mw  = o0.mag;
        nx.mdw = o1.mag;
        nx.md2 = o2.mag;
        nx.sat = o0.sat | o1.sat | o2.sat;
        pipe_next[S_O1] = nx;
    end

    always_comb
    begin
        item_t it;
        item_t nx;
        it    = pipe_reg[S_O2-1];
        nx    = it;
        nx.kv = it.mw;
        nx.fd = it.dneg ? it.mdw : (48'd0 - it.mdw);
        nx.sd = it.d2neg ? (48'd0 - it.md2) : it.md2;
        if (it.bad || it.far)
        begin
            nx.kv  = '0;
            nx.fd  = '0;
            nx.sd  = '0;
            nx.sat = 1'b0;
        end
        pipe_next[S_O2] = nx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pipe_reg <= pipe_next;
        end
    end

    assign res_next = {pipe_reg[NST-1].bad, pipe_reg[NST-1].sat, pipe_reg[NST-1].sd,
                       pipe_reg[NST-1].fd, pipe_reg[NST-1].kv};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else if (skid_vld_reg)
        begin
            if (pop)
            begin
                skid_vld_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_vld_reg <= 1'b1;
            end
            else
            begin
                out_vld_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_vld_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_vld_reg && !pop)
            begin
                skid_reg <= res_next;
            end
            else
            begin
                out_reg <= res_next;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg[143:0];
    assign m_axis_tuser  = out_reg[145:144];

`ifndef SYNTHESIS
    a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> (m_axis_tdata == '0 && !m_axis_tuser[0]))
        else $error("bad length result not cleared");

    a_skid_order : assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held without output entry");

    a_w_nonneg : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[47])
        else $error("negative kernel value");
`endif

endmodule
`default_nettype wire

@@ dv/tb_gaussian_sph_kernel_eval.sv @@
// Self-checking testbench for the Gaussian SPH kernel evaluator with its own bit-exact predictor.
`timescale 1ns / 1ps
module tb_gaussian_sph_kernel_eval;

    import gske_pkg::*;

    localparam int  FRAC = 16;
    localparam int  LIMIT_CYCLES = 400000;
    localparam int  DRAIN_CYCLES = 120;
    localparam longint unsigned Q32_ONE = 64'd4294967296;
    localparam longint unsigned Q32_LOG2E = 64'd6196328018;
    localparam longint unsigned Q32_LN2 = 64'd2977044472;
    localparam longint unsigned Q32_INVPI = 64'd1367130551;
    localparam longint unsigned Q32_INVPI15 = 64'd771320816;
    localparam longint unsigned CAP_POS = 64'h7FFF_FFFF_FFFF;
    localparam longint unsigned CAP_NEG = 64'h8000_0000_0000;

    typedef struct {
        longint unsigned m;
        int              e;
    } mant_exp_t;

    typedef struct {
        logic [143:0] data;
        logic [1:0]   user;
    } kernel_result_t;

    class kernel_scoreboard;
        bit             dim3;
        kernel_result_t expected_q[$];
        int             mismatches;

        function mant_exp_t norm(longint unsigned v, int e);
            mant_exp_t r;
            r.m = 0;
            r.e = 0;
            if (v == 0)
            begin
                return r;
            end
            while (v >= Q32_ONE)
            begin
                v = v >> 1;
                e++;
            end
            while (v < 64'h8000_0000)
            begin
                v = v << 1;
                e--;
            end
            r.m = v;
            r.e = e;
            return r;
        endfunction

        function mant_exp_t mult(mant_exp_t a, mant_exp_t b);
            if (a.m == 0 || b.m == 0)
            begin
                return norm(0, 0);
            end
            return norm(a.m * b.m, a.e + b.e);
        endfunction

        function mant_exp_t scale2(mant_exp_t a, int k);
            if (a.m != 0)
            begin
                a.e += k;
            end
            return a;
        endfunction

        function longint unsigned to_q32(mant_exp_t a);
            int s;
            s = a.e + 32;
            if (a.m == 0)
            begin
                return 0;
            end
            if (s >= 0)
            begin
                if (s > 31)
                begin
                    return '1;
                end
                return a.m << s;
            end
            if (-s >= 64)
            begin
                return 0;
            end
            return a.m >> (-s);
        endfunction

        function logic [47:0] to_out(mant_exp_t a, bit neg, inout bit sat);
            longint unsigned v;
            longint unsigned cap;
            cap = neg ? CAP_NEG : CAP_POS;
            v = 0;
            if (a.m == 0)
            begin
                return '0;
            end
            if (a.e >= 17)
            begin
                sat = 1'b1;
                v = cap;
            end
            else
            begin
                if (a.e >= 0)
                begin
                    v = a.m << a.e;
                end
                else if (-a.e < 64)
                begin
                    v = a.m >> (-a.e);
                end
                if (v > cap)
                begin
                    sat = 1'b1;
                    v = cap;
                end
            end
            return neg ? 48'(0 - v) : 48'(v);
        endfunction

        function kernel_result_t evaluate(logic [31:0] distance, logic [30:0] hlen);
            kernel_result_t  res;
            longint unsigned dmag, q, t, f, y, p, u, dmg;
            int              n, nd;
            bit              dneg, d2neg, sat;
            mant_exp_t       r, r2, ex, ih, a, w, g, h2, dw, d2;
            logic [47:0]     wv, dwv, d2v;
            res.data = '0;
            res.user = '0;
            sat = 1'b0;
            dneg = distance[31];
            dmag = dneg ? longint'(32'(-distance)) : longint'(distance);
            if (dneg && distance == 32'h8000_0000)
            begin
                dmag = 64'h8000_0000;
            end
            if (hlen == 0)
            begin
                res.user[1] = 1'b1;
                return res;
            end
            q = (dmag << 32) / longint'(hlen);
            if (q >= (64'd32 << 32))
            begin
                return res;
            end
            r = norm(q, -32);
            r2 = mult(r, r);
            t = to_q32(mult(r2, norm(Q32_LOG2E, -32)));
            n = int'(t >> 32);
            f = t & 64'hFFFF_FFFF;
            y = (f * Q32_LN2) >> 32;
            p = Q32_ONE;
            for (int k = 13; k >= 1; k--)
            begin
                p = Q32_ONE - ((y * p) >> 32) / longint'(k);
            end
            ex = norm(p, -32 - n);
            ih = norm((64'd1 << 63) / longint'(hlen), -63);
            nd = dim3 ? 3 : 2;
            a = norm(dim3 ? Q32_INVPI15 : Q32_INVPI, -32 + (nd + 1) * FRAC);
            for (int i = 0; i < nd; i++)
            begin
                a = mult(a, ih);
            end
            w = mult(a, ex);
            g = scale2(mult(w, ih), FRAC);
            dw = scale2(mult(r, g), 1);
            h2 = scale2(mult(g, ih), FRAC);
            u = 2 * to_q32(r2);
            if (u <= Q32_ONE)
            begin
                dmg = Q32_ONE - u;
                d2neg = 1'b1;
            end
            else
            begin
                dmg = u - Q32_ONE;
                d2neg = 1'b0;
            end
            d2 = scale2(mult(norm(dmg, -32), h2), 1);
            wv = to_out(w, 1'b0, sat);
            dwv = to_out(dw, !dneg, sat);
            d2v = to_out(d2, d2neg, sat);
            res.data = {d2v, dwv, wv};
            res.user = {1'b0, sat};
            return res;
        endfunction

        function void note_input(logic [63:0] tdata);
            expected_q.push_back(evaluate(tdata[31:0], tdata[62:32]));
        endfunction

        function void check_result(logic [143:0] tdata, logic [1:0] tuser);
            kernel_result_t exp_r;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transaction data=%h user=%b", tdata, tuser);
                end
                return;
            end
            exp_r = expected_q.pop_front();
            if (exp_r.data[47:0] !== tdata[47:0] || exp_r.data[95:48] !== tdata[95:48]
                || exp_r.data[143:96] !== tdata[143:96] || exp_r.user[0] !== tuser[0]
                || exp_r.user[1] !== tuser[1])
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch W exp %h got %h, dW exp %h got %h, d2W exp %h got %h",
                             exp_r.data[47:0], tdata[47:0], exp_r.data[95:48], tdata[95:48],
                             exp_r.data[143:96], tdata[143:96]);
                    $display("         sat exp %b got %b, bad_length exp %b got %b",
                             exp_r.user[0], tuser[0], exp_r.user[1], tuser[1]);
                end
            end
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic         cfg_data;

    kernel_scoreboard sb;
    int               burst_left;
    int               cycle_count;
    int               stall_mode;

    gaussian_sph_kernel_eval #(.FRAC_BITS(FRAC)) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Hold the timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_gaussian_sph_kernel_eval: FAIL");
            $finish;
        end
    end

    // Stall the result side on a pattern that is redrawn at random from four modes.
    always @(negedge clk)
    begin
        if (cycle_count % 64 == 0)
        begin
            stall_mode <= $urandom_range(0, 3);
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 9) < 7);
            2: m_axis_tready <= (cycle_count % 3 != 0);
            default: m_axis_tready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    task automatic write_dimension(bit dim);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= dim;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        sb.dim3 = dim;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(logic [31:0] distance, logic [30:0] hlen);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 20);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, hlen, distance};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_input({1'b0, hlen, distance});
        burst_left--;
        @(negedge clk);
    endtask

    task automatic send_directed();
        send_item(32'h0001_0000, 31'd0);
        send_item(32'h8000_0000, 31'd0);
        send_item(32'h0000_0000, 31'h0001_0000);
        send_item(32'h0000_8000, 31'h0001_0000);
        send_item(32'hFFFF_8000, 31'h0001_0000);
        send_item(32'h7FFF_FFFF, 31'h0001_0000);
        send_item(32'h8000_0000, 31'h0001_0000);
        send_item(32'h0020_0000, 31'h0001_0000);
        send_item(32'h001F_FFFF, 31'h0001_0000);
        send_item(32'hFFE0_0000, 31'h0001_0000);
        send_item(32'h0000_0000, 31'd1);
        send_item(32'h0000_0001, 31'd1);
        send_item(32'hFFFF_FFFF, 31'd1);
        send_item(32'h0000_0000, 31'h7FFF_FFFF);
        send_item(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(32'h8000_0000, 31'h7FFF_FFFF);
        send_item(32'h0000_B504, 31'h0001_0000);
        send_item(32'h0000_0100, 31'h0000_0100);
        send_item(32'h0000_0010, 31'h0000_0020);
        send_item(32'hFFFF_0000, 31'h0000_0100);
    endtask

    task automatic send_random(int count);
        logic [31:0]  distance;
        logic [30:0]  hlen;
        longint       dd;
        int           sel;
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
            begin
                distance = $urandom;
                hlen = 31'($urandom);
            end
            else if (sel == 1)
            begin
                distance = $urandom;
                hlen = '0;
            end
            else
            begin
                hlen = 31'($urandom) >> $urandom_range(0, 30);
                if (hlen == 0)
                begin
                    hlen = 31'd1;
                end
                dd = (longint'(hlen) * $urandom_range(0, 320)) / 64;
                if (dd > 64'h7FFF_FFFF)
                begin
                    dd = 64'h7FFF_FFFF;
                end
                distance = $urandom_range(0, 1) ? 32'(-dd) : 32'(dd);
            end
            send_item(distance, hlen);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        sb = new();
        cycle_count = 0;
        stall_mode = 0;
        burst_left = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        send_directed();
        drain();
        write_dimension(1'b1);
        send_directed();
        send_random(350);
        drain();
        write_dimension(1'b0);
        send_random(350);
        drain();
        write_dimension(1'b1);
        send_random(350);
        drain();
        write_dimension(1'b0);
        send_random(350);
        drain();
        if (sb.mismatches == 0)
        begin
            $display("tb_gaussian_sph_kernel_eval: PASS");
        end
        else
        begin
            $display("tb_gaussian_sph_kernel_eval: FAIL");
        end
        $finish;
    end

endmodule
